@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the text formatter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on the rising clock, switched off while reset is asserted.
`define CATF_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check sampled on the rising clock that also runs through reset.
`define CATF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/catf_pkg.sv @@
// ---------------------------------------------------------------------------
// catf_pkg
// Types and constants shared by the text line number and escape filter.
// ---------------------------------------------------------------------------
package catf_pkg;

  localparam int NUMBER_DIGITS_DEF = 6;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_ALL      = 3'd0,
    CFG_NUMBER_NONBLANK = 3'd1,
    CFG_SQUEEZE_BLANK   = 3'd2,
    CFG_SHOW_ENDS       = 3'd3,
    CFG_SHOW_TABS       = 3'd4,
    CFG_SHOW_NONPRINT   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic number_all_lines;
    logic number_nonblank_lines;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // One formatted output byte with its flags.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       dropped;
  } res_t;

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CH_I      = 8'd73;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CTRL_LIMIT   = 8'd32;
  localparam logic [7:0] CARET_OFFSET = 8'd64;

endpackage

@@ src/catf_if.sv @@
// ---------------------------------------------------------------------------
// catf_if
// Valid/ready channels for the raw input bytes and the formatted results.
// ---------------------------------------------------------------------------
interface catf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface catf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       dropped;

  modport source (output valid, output out_byte, output last_of_run, output dropped,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input dropped,
                  output ready);
endinterface

@@ src/catf_fmt.sv @@
// ---------------------------------------------------------------------------
// catf_fmt
// Line state and counter, and the expansion of one input byte into its run.
// ---------------------------------------------------------------------------
module catf_fmt #(
  parameter int NumberDigits = catf_pkg::NUMBER_DIGITS_DEF,
  localparam int MaxRun = NumberDigits + 3,
  localparam int CntW   = $clog2(MaxRun + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  file_start,
  input  catf_pkg::cfg_t        cfg,
  output catf_pkg::res_t        run [MaxRun],
  output logic [CntW-1:0]       run_len
);

  logic [NumberDigits-1:0][3:0] count_r, count_nxt;
  logic                         line_start_r, line_start_nxt;
  logic                         prev_blank_r, prev_blank_nxt;

  logic [NumberDigits-1:0][3:0] eff_count, inc_count;
  logic                         eff_start, eff_blank;
  logic                         is_nl, drop, put_num, all_nines, seen, carry;
  logic [7:0]                   body0, body1;
  logic [1:0]                   body_len;
  logic [7:0]                   num_byte [NumberDigits];

  always_comb begin
    eff_count = file_start ? (4*NumberDigits)'(1) : count_r;
    eff_start = file_start | line_start_r;
    eff_blank = ~file_start & prev_blank_r;
    is_nl     = (data_byte == catf_pkg::CH_NL);
    drop      = eff_start & is_nl & cfg.squeeze_blank & eff_blank;
    put_num   = ~drop & eff_start &
                (is_nl ? (cfg.number_all_lines & ~cfg.number_nonblank_lines)
                       : (cfg.number_all_lines | cfg.number_nonblank_lines));

    // Body bytes: the newline with an optional dollar, or the escaped character.
    body0    = data_byte;
    body1    = '0;
    body_len = 2'd1;
    if (is_nl) begin
      if (cfg.show_ends) begin
        body0    = catf_pkg::CH_DOLLAR;
        body1    = catf_pkg::CH_NL;
        body_len = 2'd2;
      end
    end else if (data_byte == catf_pkg::CH_TAB) begin
      if (cfg.show_tabs) begin
        body0    = catf_pkg::CH_CARET;
        body1    = catf_pkg::CH_I;
        body_len = 2'd2;
      end
    end else if (cfg.show_nonprinting && data_byte < catf_pkg::CTRL_LIMIT) begin
      body0    = catf_pkg::CH_CARET;
      body1    = data_byte + catf_pkg::CARET_OFFSET;
      body_len = 2'd2;
    end else if (cfg.show_nonprinting && data_byte == catf_pkg::CH_DEL) begin
      body0    = catf_pkg::CH_CARET;
      body1    = catf_pkg::CH_QMARK;
      body_len = 2'd2;
    end

    // Right-aligned number with leading spaces, most significant digit first.
    seen = 1'b0;
    for (int i = NumberDigits - 1; i >= 0; i--) begin
      if (eff_count[i] != 4'd0 || i == 0) seen = 1'b1;
      num_byte[NumberDigits-1-i] = seen ? (catf_pkg::CH_ZERO | {4'd0, eff_count[i]})
                                        : catf_pkg::CH_SPACE;
    end

    // Saturating BCD increment.
    all_nines = 1'b1;
    carry     = 1'b1;
    for (int i = 0; i < NumberDigits; i++) begin
      if (eff_count[i] != 4'd9) all_nines = 1'b0;
      inc_count[i] = eff_count[i];
      if (carry) begin
        if (eff_count[i] == 4'd9) begin
          inc_count[i] = 4'd0;
        end else begin
          inc_count[i] = eff_count[i] + 4'd1;
          carry        = 1'b0;
        end
      end
    end

    for (int j = 0; j < MaxRun; j++) run[j] = '0;
    if (drop) begin
      run_len = CntW'(1);
      run[0].dropped = 1'b1;
    end else if (put_num) begin
      for (int j = 0; j < NumberDigits; j++) run[j].out_byte = num_byte[j];
      run[NumberDigits].out_byte   = catf_pkg::CH_TAB;
      run[NumberDigits+1].out_byte = body0;
      run[NumberDigits+2].out_byte = body1;
      run_len = CntW'(NumberDigits + 1) + CntW'(body_len);
    end else begin
      run[0].out_byte = body0;
      run[1].out_byte = body1;
      run_len = CntW'(body_len);
    end
    for (int j = 0; j < MaxRun; j++) begin
      run[j].last_of_run = (CntW'(j) == run_len - CntW'(1));
    end

    count_nxt      = count_r;
    line_start_nxt = line_start_r;
    prev_blank_nxt = prev_blank_r;
    if (accept && !drop) begin
      count_nxt      = (put_num && !all_nines) ? inc_count : eff_count;
      line_start_nxt = is_nl;
      prev_blank_nxt = eff_start ? is_nl : eff_blank;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= (4*NumberDigits)'(1);
      line_start_r <= 1'b1;
      prev_blank_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      line_start_r <= line_start_nxt;
      prev_blank_r <= prev_blank_nxt;
    end
  end

endmodule

@@ src/catf_ser.sv @@
// ---------------------------------------------------------------------------
// catf_ser
// Output register and pending buffer: one run byte a cycle, when not stalled.
// ---------------------------------------------------------------------------
module catf_ser #(
  parameter int NumberDigits = catf_pkg::NUMBER_DIGITS_DEF,
  localparam int MaxRun = NumberDigits + 3,
  localparam int CntW   = $clog2(MaxRun + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  catf_pkg::res_t  run [MaxRun],
  input  logic [CntW-1:0] run_len,
  output logic            take_ready,
  output logic            res_valid,
  output catf_pkg::res_t  res,
  input  logic            res_ready
);

  catf_pkg::res_t  pend_r [MaxRun];
  catf_pkg::res_t  pend_nxt [MaxRun];
  logic [CntW-1:0] pend_len_r, pend_len_nxt;
  catf_pkg::res_t  out_r, out_nxt;
  logic            out_v_r, out_v_nxt;
  logic            adv;

  assign adv        = ~out_v_r | res_ready;
  assign take_ready = (pend_len_r == '0);
  assign res_valid  = out_v_r;
  assign res        = out_r;

  always_comb begin
    pend_nxt     = pend_r;
    pend_len_nxt = pend_len_r;
    out_nxt      = out_r;
    out_v_nxt    = out_v_r;
    if (accept) begin
      if (adv) begin
        out_nxt   = run[0];
        out_v_nxt = 1'b1;
        for (int j = 0; j < MaxRun - 1; j++) pend_nxt[j] = run[j+1];
        pend_nxt[MaxRun-1] = '0;
        pend_len_nxt = run_len - CntW'(1);
      end else begin
        pend_nxt     = run;
        pend_len_nxt = run_len;
      end
    end else if (adv) begin
      if (pend_len_r != '0) begin
        out_nxt   = pend_r[0];
        out_v_nxt = 1'b1;
        for (int j = 0; j < MaxRun - 1; j++) pend_nxt[j] = pend_r[j+1];
        pend_nxt[MaxRun-1] = '0;
        pend_len_nxt = pend_len_r - CntW'(1);
      end else begin
        out_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_len_r <= '0;
      out_v_r    <= 1'b0;
    end else begin
      pend_len_r <= pend_len_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule

@@ src/text_line_number_and_escape_filter_top.sv @@
// ---------------------------------------------------------------------------
// text_line_number_and_escape_filter_top
// Formats a raw text byte stream with line numbers, squeezing and escapes.
// ---------------------------------------------------------------------------
// Usage: raw bytes arrive as requests on in_ch (data_byte, file_start); the
// formatted bytes leave as requests on out_ch, one byte per request. Each
// input request expands to a run of 1 to NumberDigits+3 result requests, the
// final one flagged last_of_run. A squeezed blank line yields one result with
// dropped and last_of_run set and out_byte zero.
// Latency: the first byte of a run is on out_ch in the cycle after its input
// request is accepted when the output register is free or being drained.
// Throughput: one output byte per cycle while out_ch is not stalled, set by
// the single output register; a run of n bytes holds in_ch until its last
// byte reaches that register, so one-byte runs flow at one request per cycle.
// in_ch.ready is low while bytes of an earlier run wait in the pending
// buffer; a stalled receiver holds out_ch steady and backs up into in_ch.
// Reset (rst_n low, synchronous) clears all options, sets the line count to
// one and places the formatter at the start of a line. The cfg port writes
// one option bit per cycle; use it only while the block is idle (unenforced).
// ---------------------------------------------------------------------------
module text_line_number_and_escape_filter_top #(
  parameter int NumberDigits = catf_pkg::NUMBER_DIGITS_DEF,
  localparam int MaxRun = NumberDigits + 3,
  localparam int CntW   = $clog2(MaxRun + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  catf_in_if.sink                        in_ch,
  catf_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [catf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_wdata
);

  // Option bits; a write to an index past the last register is ignored.
  catf_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (catf_pkg::cfg_idx_t'(cfg_index))
        catf_pkg::CFG_NUMBER_ALL:      cfg_nxt.number_all_lines      = cfg_wdata;
        catf_pkg::CFG_NUMBER_NONBLANK: cfg_nxt.number_nonblank_lines = cfg_wdata;
        catf_pkg::CFG_SQUEEZE_BLANK:   cfg_nxt.squeeze_blank         = cfg_wdata;
        catf_pkg::CFG_SHOW_ENDS:       cfg_nxt.show_ends             = cfg_wdata;
        catf_pkg::CFG_SHOW_TABS:       cfg_nxt.show_tabs             = cfg_wdata;
        catf_pkg::CFG_SHOW_NONPRINT:   cfg_nxt.show_nonprinting      = cfg_wdata;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // An input request is taken only when no earlier run is left pending.
  logic            take_ready;
  logic            accept;
  catf_pkg::res_t  run [MaxRun];
  logic [CntW-1:0] run_len;
  catf_pkg::res_t  res;

  assign in_ch.ready = take_ready;
  assign accept      = in_ch.valid & take_ready;

  // The formatter works out the whole run of the accepted byte in one pass
  // and advances the line state and counter.
  catf_fmt #(.NumberDigits(NumberDigits)) u_fmt (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_ch.data_byte),
    .file_start (in_ch.file_start),
    .cfg        (cfg_r),
    .run        (run),
    .run_len    (run_len)
  );

  // The serializer loads the run and drains it through the output register.
  catf_ser #(.NumberDigits(NumberDigits)) u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .run        (run),
    .run_len    (run_len),
    .take_ready (take_ready),
    .res_valid  (out_ch.valid),
    .res        (res),
    .res_ready  (out_ch.ready)
  );

  assign out_ch.out_byte    = res.out_byte;
  assign out_ch.last_of_run = res.last_of_run;
  assign out_ch.dropped     = res.dropped;

endmodule

@@ src/catf_checker.sv @@
// ---------------------------------------------------------------------------
// catf_checker
// Port-level checks of the text formatter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module catf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_dropped
);

  // A stalled result must stay on the port unchanged.
  `CATF_ASSERT_CLK(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte), "result changed while stalled")

  // A dropped result must be flagged last and carry a zero byte.
  `CATF_ASSERT_CLK(a_drop_form, out_valid && out_dropped |-> out_last && out_byte == 8'd0, "malformed dropped result")

  // An accepted request puts a result in the output register when the output is free or being drained.
  `CATF_ASSERT_CLK(a_first_byte, in_valid && in_ready && (!out_valid || out_ready) |=> out_valid, "first byte of run not presented")

  // Reset empties the output.
  `CATF_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind text_line_number_and_escape_filter_top catf_checker u_catf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .out_last    (out_ch.last_of_run),
  .out_dropped (out_ch.dropped)
);
